// ----- hdl/pbq_pkg.sv -----
// ----------------------------------------------------------------------------
// pbq_pkg
// Shared types and constants for the process block pool and queue manager.
// ----------------------------------------------------------------------------
`default_nettype none
package pbq_pkg;
   localparam int PROCESSES = 32;
   localparam int QUEUES    = 8;
   localparam int LISTS     = QUEUES + 1;
   localparam int BW        = $clog2(PROCESSES);
   localparam int LW        = $clog2(LISTS + 1);
   localparam int CW        = $clog2(PROCESSES + 1);

   typedef logic [BW-1:0] blk_type;
   typedef logic [LW-1:0] tag_type;
   typedef logic [CW-1:0] cnt_type;

   localparam tag_type TAG_FREE = tag_type'(0);
   localparam tag_type TAG_NONE = tag_type'(QUEUES + 1);

   typedef enum logic [3:0] {
      OP_ALLOC    = 4'd0,
      OP_FREE     = 4'd1,
      OP_CLEAR    = 4'd2,
      OP_ENQ      = 4'd3,
      OP_PEEK     = 4'd4,
      OP_DEQ      = 4'd5,
      OP_REMOVE   = 4'd6,
      OP_ADDCHILD = 4'd7,
      OP_RMCHILD  = 4'd8,
      OP_DETACH   = 4'd9,
      OP_QUERY    = 4'd10
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD1,
      ST_RD2,
      ST_WR,
      ST_RESP
   } state_type;
endpackage
`default_nettype wire

// ----- hdl/process_block_pool_queue_tree_top.sv -----
// An accepted item passes through the states check (ST_RD1), spare (ST_RD2) and
// write back (ST_WR) before its result is offered in ST_RESP, where it is held
// through any output stall.
// Items do not overlap; the next item is taken only after the previous result
// is accepted.
// Reset: synchronous; the pool is rebuilt by a clearing sweep over all
// PROCESSES blocks after reset, during which no item is accepted.
// ----------------------------------------------------------------------------
// process_block_pool_queue_tree_top
// Process block pool: free list, queues and parent/child sibling lists.
// ----------------------------------------------------------------------------
`default_nettype none
module process_block_pool_queue_tree_top (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire logic [3:0]     req_operation,
   input  wire logic [2:0]     req_queue_id,
   input  wire logic [4:0]     req_block,
   input  wire logic [4:0]     req_parent_block,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output logic                rsp_ok,
   output logic [4:0]          rsp_result_block,
   output logic                rsp_queue_empty,
   output logic                rsp_no_children
);
   import pbq_pkg::*;

   // Per-block record kept in flip-flops indexed by block; the link fields
   // are read at chosen addresses, so they live in register files written
   // through the sequencer below.
   blk_type nxt_ff [PROCESSES];
   blk_type prv_ff [PROCESSES];
   tag_type tag_ff [PROCESSES];
   blk_type snx_ff [PROCESSES];
   blk_type spv_ff [PROCESSES];
   blk_type par_ff [PROCESSES];
   logic    hp_ff  [PROCESSES];
   logic    isl_ff [PROCESSES];
   blk_type cf_ff  [PROCESSES];
   blk_type cl_ff  [PROCESSES];
   cnt_type cc_ff  [PROCESSES];
   blk_type lf_ff  [LISTS];
   blk_type ll_ff  [LISTS];
   cnt_type ls_ff  [LISTS];

   logic    init_ff;
   blk_type init_cnt_ff;
   state_type st_ff, st_in;

   op_type  op_ff;
   logic [2:0] q_ff;
   blk_type b_ff, pb_ff;
   logic    ok_ff;
   blk_type res_ff;

   logic    qv, bv;
   tag_type l;
   assign qv = ({1'b0, q_ff} < 4'(QUEUES));
   assign bv = 1'b1;
   assign l  = tag_type'(q_ff) + tag_type'(1);

   assign req_ready = (st_ff == ST_IDLE) && !init_ff;
   assign rsp_valid = (st_ff == ST_RESP);
   assign rsp_ok = ok_ff;
   assign rsp_result_block = res_ff;

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: if (req_valid && req_ready) st_in = ST_RD1;
         ST_RD1:  st_in = ST_RD2;
         ST_RD2:  st_in = ST_WR;
         ST_WR:   st_in = ST_RESP;
         ST_RESP: if (rsp_ready) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   // Operands of the work: target block, go flag and the tag of the list to unlink from.
   blk_type tb_ff;
   logic    go_ff;
   tag_type ul_ff;

   always_ff @(posedge clock) begin
      blk_type p, n, t, par;
      cnt_type sz;
      if (reset) begin
         init_ff <= 1'b1;
         init_cnt_ff <= '0;
      end else if (init_ff) begin
         nxt_ff[init_cnt_ff] <= init_cnt_ff + blk_type'(1);
         prv_ff[init_cnt_ff] <= (init_cnt_ff == '0) ? '0 : init_cnt_ff - blk_type'(1);
         tag_ff[init_cnt_ff] <= TAG_FREE;
         hp_ff[init_cnt_ff]  <= 1'b0;
         isl_ff[init_cnt_ff] <= 1'b0;
         cc_ff[init_cnt_ff]  <= '0;
         if (init_cnt_ff < blk_type'(LISTS)) begin
            lf_ff[init_cnt_ff[LW-1:0]] <= '0;
            ll_ff[init_cnt_ff[LW-1:0]] <= (init_cnt_ff == '0) ? blk_type'(PROCESSES-1) : '0;
            ls_ff[init_cnt_ff[LW-1:0]] <= (init_cnt_ff == '0) ? cnt_type'(PROCESSES) : '0;
         end
         if (init_cnt_ff == blk_type'(PROCESSES-1)) init_ff <= 1'b0;
         init_cnt_ff <= init_cnt_ff + blk_type'(1);
      end else begin
         unique case (st_ff)
            ST_IDLE: if (req_valid && req_ready) begin
               op_ff <= op_type'(req_operation);
               q_ff  <= req_queue_id;
               b_ff  <= req_block;
               pb_ff <= req_parent_block;
            end
            ST_RD1: begin
               go_ff <= 1'b0;
               tb_ff <= b_ff;
               ul_ff <= l;
               res_ff <= '0;
               ok_ff <= 1'b0;
               unique case (op_ff)
                  OP_ALLOC: if (ls_ff[0] != '0) begin
                     go_ff <= 1'b1; tb_ff <= lf_ff[0]; ul_ff <= TAG_FREE;
                  end
                  OP_FREE: if (bv && tag_ff[b_ff] == TAG_NONE && !isl_ff[b_ff] &&
                               cc_ff[b_ff] == '0) go_ff <= 1'b1;
                  OP_CLEAR: if (qv && ls_ff[l] == '0) ok_ff <= 1'b1;
                  OP_ENQ: if (qv && tag_ff[b_ff] == TAG_NONE) go_ff <= 1'b1;
                  OP_PEEK: if (qv && ls_ff[l] != '0) begin
                     ok_ff <= 1'b1; res_ff <= lf_ff[l];
                  end
                  OP_DEQ: if (qv && ls_ff[l] != '0) begin
                     go_ff <= 1'b1; tb_ff <= lf_ff[l];
                  end
                  OP_REMOVE: if (qv && tag_ff[b_ff] == l) go_ff <= 1'b1;
                  OP_ADDCHILD: if (!isl_ff[b_ff]) go_ff <= 1'b1;
                  OP_RMCHILD: if (cc_ff[b_ff] != '0) begin
                     go_ff <= 1'b1; tb_ff <= cf_ff[b_ff];
                  end
                  OP_DETACH: if (hp_ff[b_ff] && isl_ff[b_ff]) go_ff <= 1'b1;
                  OP_QUERY: begin ok_ff <= 1'b1; res_ff <= b_ff; end
                  default: ;
               endcase
            end
            ST_RD2: ;
            ST_WR: begin
               t = tb_ff;
               if (go_ff) begin
                  ok_ff <= 1'b1;
                  res_ff <= t;
                  unique case (op_ff)
                     OP_ALLOC, OP_DEQ, OP_REMOVE: begin
                        p = prv_ff[t]; n = nxt_ff[t];
                        if (lf_ff[ul_ff] == t) lf_ff[ul_ff] <= n; else nxt_ff[p] <= n;
                        if (ll_ff[ul_ff] == t) ll_ff[ul_ff] <= p; else prv_ff[n] <= p;
                        ls_ff[ul_ff] <= ls_ff[ul_ff] - cnt_type'(1);
                        tag_ff[t] <= TAG_NONE;
                        if (op_ff == OP_ALLOC) begin
                           hp_ff[t] <= 1'b0; isl_ff[t] <= 1'b0; cc_ff[t] <= '0;
                        end
                     end
                     OP_FREE, OP_ENQ: begin
                        sz = ls_ff[(op_ff == OP_FREE) ? TAG_FREE : l];
                        tag_ff[t] <= (op_ff == OP_FREE) ? TAG_FREE : l;
                        nxt_ff[t] <= '0;
                        if (op_ff == OP_FREE) begin
                           if (sz == '0) begin lf_ff[0] <= t; prv_ff[t] <= '0; end
                           else begin nxt_ff[ll_ff[0]] <= t; prv_ff[t] <= ll_ff[0]; end
                           ll_ff[0] <= t; ls_ff[0] <= sz + cnt_type'(1);
                        end else begin
                           if (sz == '0) begin lf_ff[l] <= t; prv_ff[t] <= '0; end
                           else begin nxt_ff[ll_ff[l]] <= t; prv_ff[t] <= ll_ff[l]; end
                           ll_ff[l] <= t; ls_ff[l] <= sz + cnt_type'(1);
                        end
                        if (ll_ff[(op_ff == OP_FREE) ? TAG_FREE : l] == t && sz != '0)
                           nxt_ff[t] <= t;
                     end
                     OP_ADDCHILD: begin
                        par_ff[t] <= pb_ff; hp_ff[t] <= 1'b1; isl_ff[t] <= 1'b1;
                        snx_ff[t] <= '0;
                        if (cc_ff[pb_ff] == '0) begin cf_ff[pb_ff] <= t; spv_ff[t] <= '0; end
                        else begin
                           snx_ff[cl_ff[pb_ff]] <= t; spv_ff[t] <= cl_ff[pb_ff];
                           if (cl_ff[pb_ff] == t) snx_ff[t] <= t;
                        end
                        cl_ff[pb_ff] <= t; cc_ff[pb_ff] <= cc_ff[pb_ff] + cnt_type'(1);
                     end
                     OP_RMCHILD, OP_DETACH: begin
                        par = (op_ff == OP_RMCHILD) ? b_ff : par_ff[t];
                        p = spv_ff[t]; n = snx_ff[t];
                        if (cf_ff[par] == t) cf_ff[par] <= n; else snx_ff[p] <= n;
                        if (cl_ff[par] == t) cl_ff[par] <= p; else spv_ff[n] <= p;
                        cc_ff[par] <= cc_ff[par] - cnt_type'(1);
                        isl_ff[t] <= 1'b0;
                     end
                     default: ;
                  endcase
               end
            end
            ST_RESP: ;
            default: ;
         endcase
      end
   end

   // Status flags read from the state left by the write back.
   logic qe_now, nc_now;
   assign qe_now = qv ? (ls_ff[l] == '0) : 1'b1;
   assign nc_now = (cc_ff[b_ff] == '0);

   assign rsp_queue_empty = qe_now;
   assign rsp_no_children = nc_now;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid) else $error("ready while result pending");
   a_init_block: assert property (@(posedge clock) disable iff (reset)
      init_ff |-> !req_ready) else $error("item taken during sweep");
   a_resp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
endmodule
`default_nettype wire

// ----- verif/pbq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbq_checker
// Watches the command and response channels, keeps a shadow of the block
// pool, its queues and the process tree, and compares every response.
// ----------------------------------------------------------------------------
module pbq_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [3:0] req_operation,
   input  logic [2:0] req_queue_id,
   input  logic [4:0] req_block,
   input  logic [4:0] req_parent_block,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic       rsp_ok,
   input  logic [4:0] rsp_result_block,
   input  logic       rsp_queue_empty,
   input  logic       rsp_no_children,
   output int         pending,
   output int         errors
);
   import pbq_pkg::*;

   typedef struct packed {
      logic    ok;
      blk_type blk;
      logic    q_empty;
      logic    childless;
   } answer_type;

   answer_type awaited[$];

   blk_type nxt[PROCESSES], prv[PROCESSES];
   tag_type owner[PROCESSES];
   blk_type head[LISTS], tail[LISTS];
   cnt_type count[LISTS];
   blk_type sib_nxt[PROCESSES], sib_prv[PROCESSES], parent[PROCESSES];
   logic    parented[PROCESSES], in_sibs[PROCESSES];
   blk_type kid_head[PROCESSES], kid_tail[PROCESSES];
   cnt_type kids[PROCESSES];

   task automatic report(input string what, input logic [5:0] got, input logic [5:0] want);
      errors++;
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   function automatic void pool_clear();
      for (int i = 0; i < PROCESSES; i++) begin
         nxt[i] = blk_type'((i + 1) % PROCESSES);
         prv[i] = blk_type'(i > 0 ? i - 1 : 0);
         owner[i] = TAG_FREE;
         parented[i] = 0;
         in_sibs[i] = 0;
         kids[i] = 0;
      end
      for (int l = 0; l < LISTS; l++) begin
         head[l] = 0;
         tail[l] = 0;
         count[l] = 0;
      end
      tail[0] = blk_type'(PROCESSES - 1);
      count[0] = cnt_type'(PROCESSES);
   endfunction

   function automatic void append(input int l, input blk_type b);
      owner[b] = tag_type'(l);
      nxt[b] = 0;
      if (count[l] == 0) begin
         head[l] = b;
         prv[b] = 0;
      end else begin
         nxt[tail[l]] = b;
         prv[b] = tail[l];
      end
      tail[l] = b;
      count[l]++;
   endfunction

   function automatic void take_out(input int l, input blk_type b);
      blk_type p, n;
      p = prv[b];
      n = nxt[b];
      if (head[l] == b) head[l] = n; else nxt[p] = n;
      if (tail[l] == b) tail[l] = p; else prv[n] = p;
      count[l]--;
      owner[b] = TAG_NONE;
   endfunction

   function automatic void orphan(input blk_type par, input blk_type c);
      blk_type p, n;
      p = sib_prv[c];
      n = sib_nxt[c];
      if (kid_head[par] == c) kid_head[par] = n; else sib_nxt[p] = n;
      if (kid_tail[par] == c) kid_tail[par] = p; else sib_prv[n] = p;
      kids[par]--;
      in_sibs[c] = 0;
   endfunction

   function automatic answer_type execute(input logic [3:0] op, input logic [2:0] q,
                                          input blk_type b, input blk_type pb);
      answer_type a;
      int l;
      l = q + 1;
      a = '0;
      case (op)
         OP_ALLOC: begin
            if (count[0] != 0) begin
               a.blk = head[0];
               take_out(0, a.blk);
               parented[a.blk] = 0;
               in_sibs[a.blk] = 0;
               kids[a.blk] = 0;
               a.ok = 1;
            end
         end
         OP_FREE: begin
            if (owner[b] == TAG_NONE && !in_sibs[b] && kids[b] == 0) begin
               append(0, b);
               a.ok = 1;
               a.blk = b;
            end
         end
         OP_CLEAR: a.ok = (count[l] == 0);
         OP_ENQ: begin
            if (owner[b] == TAG_NONE) begin
               append(l, b);
               a.ok = 1;
               a.blk = b;
            end
         end
         OP_PEEK: begin
            if (count[l] != 0) begin
               a.ok = 1;
               a.blk = head[l];
            end
         end
         OP_DEQ: begin
            if (count[l] != 0) begin
               a.blk = head[l];
               take_out(l, a.blk);
               a.ok = 1;
            end
         end
         OP_REMOVE: begin
            if (owner[b] == tag_type'(l)) begin
               take_out(l, b);
               a.ok = 1;
               a.blk = b;
            end
         end
         OP_ADDCHILD: begin
            if (!in_sibs[b]) begin
               parent[b] = pb;
               parented[b] = 1;
               in_sibs[b] = 1;
               sib_nxt[b] = 0;
               if (kids[pb] == 0) begin
                  kid_head[pb] = b;
                  sib_prv[b] = 0;
               end else begin
                  sib_nxt[kid_tail[pb]] = b;
                  sib_prv[b] = kid_tail[pb];
               end
               kid_tail[pb] = b;
               kids[pb]++;
               a.ok = 1;
               a.blk = b;
            end
         end
         OP_RMCHILD: begin
            if (kids[b] != 0) begin
               a.blk = kid_head[b];
               orphan(b, a.blk);
               a.ok = 1;
            end
         end
         OP_DETACH: begin
            if (parented[b] && in_sibs[b]) begin
               orphan(parent[b], b);
               a.ok = 1;
               a.blk = b;
            end
         end
         OP_QUERY: begin
            a.ok = 1;
            a.blk = b;
         end
         default: ;
      endcase
      a.q_empty = (count[l] == 0);
      a.childless = (kids[b] == 0);
      return a;
   endfunction

   initial errors = 0;

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         pool_clear();
         awaited.delete();
         pending <= 0;
      end else begin
         if (req_valid && req_ready)
            awaited.push_back(execute(req_operation, req_queue_id, req_block,
                                      req_parent_block));
         if (rsp_valid && rsp_ready) begin
            if (awaited.size() == 0) begin
               errors++;
               $display("%0t: response with no command outstanding", $time);
            end else begin
               want = awaited.pop_front();
               if (rsp_ok !== want.ok) report("ok", 6'(rsp_ok), 6'(want.ok));
               if (rsp_result_block !== want.blk)
                  report("result_block", 6'(rsp_result_block), 6'(want.blk));
               if (rsp_queue_empty !== want.q_empty)
                  report("queue_empty", 6'(rsp_queue_empty), 6'(want.q_empty));
               if (rsp_no_children !== want.childless)
                  report("no_children", 6'(rsp_no_children), 6'(want.childless));
            end
         end
         pending <= awaited.size();
      end
   end
endmodule

// ----- verif/tb_process_block_pool_queue_tree_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_process_block_pool_queue_tree_top
// Drives directed and random pool, queue and tree commands under varying
// back-pressure; the checker predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_process_block_pool_queue_tree_top;
   import pbq_pkg::*;

   logic       clock = 0;
   logic       reset = 1;
   logic       req_valid = 0;
   logic       req_ready;
   logic [3:0] req_operation = '0;
   logic [2:0] req_queue_id = '0;
   logic [4:0] req_block = '0;
   logic [4:0] req_parent_block = '0;
   logic       rsp_valid;
   logic       rsp_ready = 0;
   logic       rsp_ok;
   logic [4:0] rsp_result_block;
   logic       rsp_queue_empty;
   logic       rsp_no_children;
   int         pending, errors;
   int         send_idle = 12, recv_idle = 58;

   always #5 clock = ~clock;

   process_block_pool_queue_tree_top dut (.*);
   pbq_checker checker_inst (.*);

   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_idle);

   task automatic issue(input op_type op, input int q, input int b, input int pb);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid        <= 1;
      req_operation    <= op;
      req_queue_id     <= 3'(q);
      req_block        <= 5'(b);
      req_parent_block <= 5'(pb);
      do @(posedge clock); while (!req_ready);
   endtask

   // weighted toward allocation and linking so queues and trees grow deep
   function automatic op_type pick_op();
      int r;
      r = $urandom_range(99);
      if (r < 14) return OP_ALLOC;
      if (r < 22) return OP_FREE;
      if (r < 26) return OP_CLEAR;
      if (r < 40) return OP_ENQ;
      if (r < 45) return OP_PEEK;
      if (r < 53) return OP_DEQ;
      if (r < 59) return OP_REMOVE;
      if (r < 73) return OP_ADDCHILD;
      if (r < 81) return OP_RMCHILD;
      if (r < 89) return OP_DETACH;
      if (r < 97) return OP_QUERY;
      return op_type'($urandom_range(15, 11));
   endfunction

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      issue(OP_QUERY, 0, 31, 0);
      issue(OP_ALLOC, 0, 0, 0);
      issue(OP_ALLOC, 0, 0, 0);
      issue(OP_ALLOC, 0, 0, 0);
      issue(OP_FREE, 0, 31, 0);       // still on the free list
      issue(OP_PEEK, 7, 0, 0);        // empty queue
      issue(OP_DEQ, 7, 0, 0);
      issue(OP_ENQ, 0, 0, 0);
      issue(OP_ENQ, 0, 0, 0);         // already linked
      issue(OP_ENQ, 7, 1, 0);
      issue(OP_CLEAR, 0, 0, 0);       // non-empty, refused
      issue(OP_PEEK, 0, 0, 0);
      issue(OP_REMOVE, 0, 1, 0);      // wrong queue
      issue(OP_REMOVE, 7, 1, 0);
      issue(OP_DEQ, 0, 0, 0);
      issue(OP_CLEAR, 0, 0, 0);
      issue(OP_ADDCHILD, 0, 2, 31);
      issue(OP_ADDCHILD, 0, 0, 0);    // child of itself
      issue(OP_ADDCHILD, 0, 2, 0);    // already a child
      issue(OP_FREE, 0, 2, 0);        // in a sibling list
      issue(OP_RMCHILD, 0, 0, 0);
      issue(OP_DETACH, 0, 0, 0);      // no longer in a sibling list
      issue(OP_DETACH, 0, 2, 0);
      issue(OP_FREE, 0, 1, 0);
      issue(op_type'(15), 7, 31, 31);
      for (int phase = 0; phase < 3; phase++) begin
         drain();
         send_idle = (phase == 0) ? 12 : (phase == 1) ? 58 : 0;
         recv_idle = (phase == 0) ? 58 : (phase == 1) ? 12 : 0;
         for (int i = 0; i < 500; i++)
            issue(pick_op(), $urandom_range(7), $urandom_range(31), $urandom_range(31));
      end
      drain();
      repeat (20) @(posedge clock);
      if (errors == 0 && pending == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #5ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
